@@ sv/mau_pkg.sv @@
// Package for the modular arithmetic unit: command codes and shared sizes.
`timescale 1ns / 1ps
`default_nettype none
package mau_pkg;

  localparam int unsigned OpWidth  = 64;
  localparam int unsigned ExpWidth = 63;

  localparam logic [2:0] CMD_REDUCE = 3'd0;
  localparam logic [2:0] CMD_ADD    = 3'd1;
  localparam logic [2:0] CMD_SUB    = 3'd2;
  localparam logic [2:0] CMD_MUL    = 3'd3;
  localparam logic [2:0] CMD_DIV    = 3'd4;
  localparam logic [2:0] CMD_POW    = 3'd5;
  localparam logic [2:0] CMD_NEG    = 3'd6;
  localparam logic [2:0] CMD_INV    = 3'd7;

  localparam logic [31:0] MOD_RESET = 32'd1000000007;

  localparam logic [1:0] ADDR_MODULUS = 2'd0;

endpackage
`default_nettype wire

@@ sv/modular_arithmetic_unit.sv @@
// Modular arithmetic unit: top level with APB modulus register and sequencer.
// Operands a and b are reduced in turn; reduce/add/sub/neg then finish, mul reduces one product,
// pow reduces one product per multiply or square over the bits of its 63-bit exponent; inv and
// div raise to m-2 (div then multiplies by a), so their work is set by the bits of m-2.
// One item at a time: input ready again the cycle after the result is registered.
// Reset: modulus returns to 1000000007, sequencer idle, output empty.
`timescale 1ns / 1ps
`default_nettype none
module modular_arithmetic_unit #(
  parameter int unsigned MOD_WIDTH = 31
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [1:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata: operand_a[63:0], operand_b[127:64], exponent[190:128], pad
  input  wire logic [191:0] s_axis_tdata,
  // tuser: cmd[2:0]
  input  wire logic [2:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata: result[30:0], a_less_b[31], a_equals_b[32], pad
  output logic [39:0]       m_axis_tdata
);
  import mau_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0, ST_RA = 4'd1, ST_RB = 4'd2, ST_OP = 4'd3,
                         ST_MULW = 4'd4, ST_PSTEP = 4'd5, ST_PSQW = 4'd6,
                         ST_FINAL = 4'd7, ST_OUT = 4'd8, ST_PACCW = 4'd9;

  logic [MOD_WIDTH-1:0] mod_q;
  logic [MOD_WIDTH-1:0] m_eff;
  logic                 m_small;

  // register port
  assign pready = 1'b1;
  assign prdata = 32'(mod_q);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= MOD_WIDTH'(MOD_RESET);
    end else if (psel && penable && pwrite && paddr == ADDR_MODULUS) begin
      mod_q <= pwdata[MOD_WIDTH-1:0];
    end
  end
  assign m_small = (mod_q < MOD_WIDTH'(2));
  assign m_eff   = m_small ? MOD_WIDTH'(1) : mod_q;

  logic [3:0]           st_q;
  logic [2:0]           cmd_q;
  logic [63:0]          opb_q;
  logic [ExpWidth-1:0]  exp_q;
  logic [MOD_WIDTH-1:0] a_q, b_q, acc_q, base_q, res_q;
  logic                 nega_q, lt_q, eq_q;
  logic [39:0]          out_q;
  logic                 ovalid_q;

  logic                 red_start;
  logic [63:0]          red_val;
  logic                 red_done;
  logic [MOD_WIDTH-1:0] red_rem;

  mau_modred #(.MOD_WIDTH(MOD_WIDTH)) u_red (
    .clk_i, .rst_ni, .start_i(red_start), .value_i(red_val),
    .mod_i(m_eff), .done_o(red_done), .rem_o(red_rem)
  );

  // fix up a signed reduction
  logic [MOD_WIDTH-1:0] signed_rem;
  assign signed_rem = (nega_q && red_rem != '0) ? m_eff - red_rem : red_rem;

  logic [63:0] abs_b;
  assign abs_b = opb_q[63] ? 64'(0) - opb_q : opb_q;

  // modular add and subtract helpers
  logic [MOD_WIDTH:0] sum_ab, sum_nb;
  assign sum_ab = {1'b0, a_q} + {1'b0, b_q};
  assign sum_nb = {1'b0, a_q} + ({1'b0, m_eff} - {1'b0, b_q});

  // one shared product, operands chosen by state
  logic [MOD_WIDTH-1:0] mx, my;
  logic [63:0]          prod;
  assign prod = 64'(mx) * 64'(my);

  always_comb begin
    mx = a_q;
    my = b_q;
    if (st_q == ST_PSTEP) begin
      mx = exp_q[0] ? acc_q : base_q;
      my = base_q;
    end else if (st_q == ST_FINAL) begin
      my = acc_q;
    end
  end

  always_comb begin
    red_start = 1'b0;
    red_val   = prod;
    case (st_q)
      ST_IDLE: begin
        red_start = s_axis_tvalid;
        red_val   = s_axis_tdata[63] ? 64'(0) - s_axis_tdata[63:0] : s_axis_tdata[63:0];
      end
      ST_RA: begin
        red_start = red_done;
        red_val   = abs_b;
      end
      ST_OP: red_start = (cmd_q == CMD_MUL);
      ST_PSTEP: red_start = (exp_q != '0);
      ST_FINAL: red_start = (cmd_q == CMD_DIV);
      default: ;
    endcase
  end

  assign s_axis_tready = (st_q == ST_IDLE);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      if (st_q == ST_OUT && (!ovalid_q || m_axis_tready)) begin
        ovalid_q <= 1'b1;
      end else if (ovalid_q && m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
      case (st_q)
        ST_IDLE: if (s_axis_tvalid) st_q <= ST_RA;
        ST_RA: if (red_done) st_q <= ST_RB;
        ST_RB: if (red_done) st_q <= ST_OP;
        ST_OP: begin
          case (cmd_q)
            CMD_MUL: st_q <= ST_MULW;
            CMD_DIV, CMD_POW, CMD_INV: st_q <= ST_PSTEP;
            default: st_q <= ST_OUT;
          endcase
        end
        ST_MULW: if (red_done) st_q <= ST_OUT;
        ST_PSTEP: if (exp_q == '0) st_q <= ST_FINAL;
                  else st_q <= exp_q[0] ? ST_PACCW : ST_PSQW;
        ST_PACCW: if (red_done) st_q <= ST_PSTEP;
        ST_PSQW: if (red_done) st_q <= ST_PSTEP;
        ST_FINAL: st_q <= (cmd_q == CMD_DIV) ? ST_MULW : ST_OUT;
        ST_OUT: if (!ovalid_q || m_axis_tready) st_q <= ST_IDLE;
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: if (s_axis_tvalid) begin
        cmd_q  <= s_axis_tuser;
        opb_q  <= s_axis_tdata[127:64];
        exp_q  <= s_axis_tdata[190:128];
        nega_q <= s_axis_tdata[63];
      end
      ST_RA: if (red_done) begin
        a_q    <= signed_rem;
        nega_q <= opb_q[63];
      end
      ST_RB: if (red_done) begin
        b_q  <= signed_rem;
        lt_q <= a_q < signed_rem;
        eq_q <= a_q == signed_rem;
      end
      ST_OP: begin
        acc_q <= m_small ? '0 : MOD_WIDTH'(1);
        case (cmd_q)
          CMD_REDUCE: res_q <= a_q;
          CMD_ADD: res_q <= (sum_ab >= {1'b0, m_eff}) ? MOD_WIDTH'(sum_ab - {1'b0, m_eff})
                                                   : sum_ab[MOD_WIDTH-1:0];
          CMD_SUB: res_q <= (sum_nb >= {1'b0, m_eff}) ? MOD_WIDTH'(sum_nb - {1'b0, m_eff})
                                                   : sum_nb[MOD_WIDTH-1:0];
          CMD_NEG: res_q <= (a_q == '0) ? '0 : m_eff - a_q;
          CMD_POW: base_q <= a_q;
          CMD_DIV: begin
            base_q <= b_q;
            exp_q  <= ExpWidth'(m_small ? '0 : m_eff - MOD_WIDTH'(2));
          end
          CMD_INV: begin
            base_q <= a_q;
            exp_q  <= ExpWidth'(m_small ? '0 : m_eff - MOD_WIDTH'(2));
          end
          default: res_q <= a_q;
        endcase
      end
      ST_MULW: if (red_done) res_q <= red_rem;
      ST_PACCW: if (red_done) begin
        acc_q <= red_rem;
        exp_q <= {exp_q[ExpWidth-1:1], 1'b0};
      end
      ST_PSQW: if (red_done) begin
        base_q <= red_rem;
        exp_q  <= exp_q >> 1;
      end
      ST_FINAL: begin
        res_q <= acc_q;
        b_q   <= acc_q;
      end
      ST_OUT: if (!ovalid_q || m_axis_tready) begin
        out_q <= {7'd0, eq_q, lt_q, 31'(m_small ? '0 : res_q)};
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = out_q;
endmodule
`default_nettype wire

@@ sv/mau_modred.sv @@
// Restoring bit-serial reducer: 64-bit unsigned value modulo m, one bit a cycle.
`timescale 1ns / 1ps
`default_nettype none
module mau_modred #(
  parameter int unsigned MOD_WIDTH = 31
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [63:0]          value_i,
  input  wire logic [MOD_WIDTH-1:0] mod_i,
  output logic                      done_o,
  output logic [MOD_WIDTH-1:0]      rem_o
);
  import mau_pkg::*;

  logic [63:0]          val_q, val_d;
  logic [MOD_WIDTH-1:0] rem_q, rem_d;
  logic [6:0]           cnt_q, cnt_d;
  logic                 busy_q, busy_d, done_q, done_d;
  logic [MOD_WIDTH:0]   shifted;

  // one shift-subtract step per cycle
  always_comb begin
    val_d  = val_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    shifted = {rem_q, val_q[63]};
    if (start_i) begin
      val_d  = value_i;
      rem_d  = '0;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      val_d = {val_q[62:0], 1'b0};
      if (shifted >= {1'b0, mod_i}) begin
        rem_d = MOD_WIDTH'(shifted - {1'b0, mod_i});
      end else begin
        rem_d = shifted[MOD_WIDTH-1:0];
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire
